### rtl/core/lru_block_cache_directory_unit_assert.svh
// Assertion macros used by the directory engine.
// Each macro takes a label, the clock, the reset and the two sides of an implication.
`ifndef LRU_BLOCK_CACHE_DIRECTORY_UNIT_ASSERT_SVH
`define LRU_BLOCK_CACHE_DIRECTORY_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define LBCD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("directory check failed");

// Next-cycle implication.
`define LBCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("directory check failed");

`else

`define LBCD_ASSERT_IMP(label, clk, rst, ante, cons)
`define LBCD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/lbcd_pkg.sv
package lbcd_pkg;

  // Default number of directory entries.
  localparam int ENTRIES_DEFAULT = 16;

  // Field widths of a request and a result.
  localparam int BLOCK_W    = 32;
  localparam int BUF_SLOT_W = 4;

  // Depth of the request and result queues.
  localparam int QUEUE_DEPTH = 2;

  // One result as it travels from the engine to the result queue.
  typedef struct packed {
    logic                  hit;
    logic [BUF_SLOT_W-1:0] buffer_slot;
    logic                  evicted_valid;
    logic [BLOCK_W-1:0]    evicted_block;
  } result_t;

  // Handshake between a queue and the engine.
  typedef struct packed {
    logic valid;
    logic ready;
  } link_t;

endpackage

### rtl/core/lru_block_cache_directory_unit.sv
// Fully associative block directory with least-recently-used replacement.
// Request channel: block_number is taken at a clock edge with push high and full low.
// Result channel: while empty is low the oldest result sits on hit, buffer_slot,
// evicted_valid and evicted_block; it is taken at an edge with pop high.
// Each request gives exactly one result, in request order.
// A hit moves the entry to the most recent place; a miss fills the next free
// buffer slot (0, 1, 2, ...) or, when all entries are held, replaces the least
// recent entry, keeps its buffer slot and reports its old block number.
// Requests pass from the request queue through the engine to the result queue.
// The directory engine handles one request at a time in its compare, encode and
// shift steps, and takes the next request only as it pushes the result.
// Two-entry queues sit on both sides, so requests are taken while a result
// waits; when the receiver stalls, both queues fill and full goes high.
// Reset (rst, synchronous) empties the directory and both queues.
module lru_block_cache_directory_unit #(
  parameter int ENTRIES = lbcd_pkg::ENTRIES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [lbcd_pkg::BLOCK_W-1:0]    block_number,
  output logic                            empty,
  input  logic                            pop,
  output logic                            hit,
  output logic [lbcd_pkg::BUF_SLOT_W-1:0] buffer_slot,
  output logic                            evicted_valid,
  output logic [lbcd_pkg::BLOCK_W-1:0]    evicted_block
);

  localparam int RES_W = $bits(lbcd_pkg::result_t);

  logic                         req_empty;
  logic [lbcd_pkg::BLOCK_W-1:0] req_block;
  logic                         req_pop;
  logic                         res_full;
  logic                         res_push;
  lbcd_pkg::result_t            res;
  lbcd_pkg::result_t            res_out;
  logic [RES_W-1:0]             res_rdata;
  lbcd_pkg::link_t              req_link;
  lbcd_pkg::link_t              res_link;

  // Front: request queue.
  lbcd_fifo #(
    .WIDTH (lbcd_pkg::BLOCK_W),
    .DEPTH (lbcd_pkg::QUEUE_DEPTH)
  ) u_req_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (block_number),
    .full  (full),
    .pop   (req_pop),
    .rdata (req_block),
    .empty (req_empty)
  );

  assign req_link.valid = !req_empty;
  assign req_link.ready = 1'b1;
  assign res_link.valid = 1'b1;
  assign res_link.ready = !res_full;

  // Middle: directory engine.
  lbcd_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_link  (req_link),
    .req_block (req_block),
    .req_pop   (req_pop),
    .res_link  (res_link),
    .res_push  (res_push),
    .res       (res)
  );

  // Result queue toward the receiver.
  lbcd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (lbcd_pkg::QUEUE_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_out       = lbcd_pkg::result_t'(res_rdata);
  assign hit           = res_out.hit;
  assign buffer_slot   = res_out.buffer_slot;
  assign evicted_valid = res_out.evicted_valid;
  assign evicted_block = res_out.evicted_block;

endmodule

### rtl/core/lbcd_fifo.sv
module lbcd_fifo #(
  parameter int WIDTH = lbcd_pkg::BLOCK_W,
  parameter int DEPTH = lbcd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

### rtl/core/lbcd_engine.sv
`include "lru_block_cache_directory_unit_assert.svh"

module lbcd_engine #(
  parameter int ENTRIES = lbcd_pkg::ENTRIES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lbcd_pkg::link_t              req_link,
  input  logic [lbcd_pkg::BLOCK_W-1:0] req_block,
  output logic                         req_pop,
  input  lbcd_pkg::link_t              res_link,
  output logic                         res_push,
  output lbcd_pkg::result_t            res
);

  localparam int SW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;
  localparam logic [1:0] S_MOVE = 2'd3;

  logic [lbcd_pkg::BLOCK_W-1:0] tags  [ENTRIES];
  logic [SW-1:0]                slots [ENTRIES];
  logic [CW-1:0]                count;
  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic [lbcd_pkg::BLOCK_W-1:0] blk;
  logic [ENTRIES-1:0]           match;
  logic [SW-1:0]                pos;
  logic                         found;
  logic [SW-1:0]                hit_slot;

  logic [SW-1:0]                pos_next;
  logic [SW-1:0]                hit_slot_next;
  logic                         full;
  logic [SW-1:0]                upto;
  logic [SW-1:0]                slot;
  logic                         evict;
  logic                         take;
  logic [SW+lbcd_pkg::BUF_SLOT_W-1:0] slot_ext;

  // Encode the one-hot match and pick the matching buffer slot.
  always_comb begin
    pos_next      = '0;
    hit_slot_next = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        pos_next      = pos_next | SW'(i);
        hit_slot_next = hit_slot_next | slots[i];
      end
    end
  end

  // Decide the move: hit, fill a free slot, or evict the oldest entry.
  always_comb begin
    full  = (count == CW'(ENTRIES));
    evict = 1'b0;
    if (found) begin
      upto = pos;
      slot = hit_slot;
    end else if (!full) begin
      upto = count[SW-1:0];
      slot = count[SW-1:0];
    end else begin
      upto  = SW'(ENTRIES - 1);
      slot  = slots[ENTRIES-1];
      evict = 1'b1;
    end
  end

  // Result fields for the request under update.
  always_comb begin
    slot_ext          = {{lbcd_pkg::BUF_SLOT_W{1'b0}}, slot};
    res.hit           = found;
    res.buffer_slot   = slot_ext[lbcd_pkg::BUF_SLOT_W-1:0];
    res.evicted_valid = evict;
    res.evicted_block = evict ? tags[ENTRIES-1] : '0;
  end

  // Sequencer: take a request, compare, encode, then move and report.
  always_comb begin
    state_next = state;
    res_push   = 1'b0;
    take       = 1'b0;
    unique case (state)
      S_IDLE: begin
        take = req_link.valid;
      end
      S_LOOK: begin
        state_next = S_FIND;
      end
      S_FIND: begin
        state_next = S_MOVE;
      end
      S_MOVE: begin
        if (res_link.ready) begin
          res_push   = 1'b1;
          take       = req_link.valid;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (take) begin
      state_next = S_LOOK;
    end
  end

  assign req_pop = take;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (res_push && !found && !full) begin
        count <= count + 1'b1;
      end
    end
  end

  // Working registers of the request in flight.
  always_ff @(posedge clk) begin
    if (take) begin
      blk <= req_block;
    end
    if (state == S_LOOK) begin
      for (int i = 0; i < ENTRIES; i++) begin
        match[i] <= (tags[i] == blk) && (CW'(i) < count);
      end
    end
    if (state == S_FIND) begin
      pos      <= pos_next;
      found    <= |match;
      hit_slot <= hit_slot_next;
    end
  end

  // Recency order: shift entries down to the vacated place, new entry at the front.
  always_ff @(posedge clk) begin
    if (res_push) begin
      for (int i = 1; i < ENTRIES; i++) begin
        if (SW'(i) <= upto) begin
          tags[i]  <= tags[i-1];
          slots[i] <= slots[i-1];
        end
      end
      tags[0]  <= blk;
      slots[0] <= slot;
    end
  end

  `LBCD_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CW'(ENTRIES))
  `LBCD_ASSERT_IMP(a_match_unique, clk, rst, state == S_FIND, $onehot0(match))
  `LBCD_ASSERT_IMP(a_evict_when_full, clk, rst, res_push && res.evicted_valid, full)
  `LBCD_ASSERT_NEXT(a_fill_counts, clk, rst, res_push && !found && !full,
                    count == $past(count) + 1'b1)

endmodule
